>>> rtl/kofn_pkg.sv
// ----------------------------------------------------------------------------
// kofn_pkg: shared types and constants of the k-of-n combination generator
// Field widths, register map, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package kofn_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_CHOOSE_DEF = 8;
	localparam int MAX_SET_DEF    = 63;

	// Fixed widths of the register and result fields.
	localparam int SET_SIZE_W = 6;
	localparam int CHOOSE_W   = 4;
	localparam int VALUE_W    = 6;
	localparam int POSITION_W = 3;

	// Register map: two 32-bit registers at byte addresses 0 and 4.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_SET_SIZE     = 1'b0;
	localparam logic REG_CHOOSE_COUNT = 1'b1;

	// Register reset values.
	localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST     = SET_SIZE_W'(4);
	localparam logic [CHOOSE_W-1:0]   CHOOSE_COUNT_RST = CHOOSE_W'(2);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RD,
		ST_LD,
		ST_DONE_OUT
	} kofn_state_t;

endpackage

>>> rtl/kofn_comb_mem.sv
// ----------------------------------------------------------------------------
// kofn_comb_mem: storage of the current combination
// One write port and one registered read port; entries never written read
// as zero through per-entry valid bits that reset clears.
// ----------------------------------------------------------------------------
module kofn_comb_mem #(
	parameter int DEPTH = 8,
	parameter int DW    = 6,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_data_q;

	// Array write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// An entry becomes valid once written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read; an unwritten entry reads as zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/k_of_n_combination_generator.sv
// ----------------------------------------------------------------------------
// k_of_n_combination_generator: lexicographic k-of-n combination generator
// Each request emits the next k-element subset of 1..n as a run of k results,
// or one done result once the enumeration is finished or k is 0 or above n.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   restart
//   out      output     out_valid / out_stall element_value, element_position,
//                                             last_of_run, done_res
//   cfg      input      APB psel/penable      set_size (0x0), choose_count (0x4)
//
// A request is taken only while the sequencer is idle. An advance reads the
// stored elements from the last position down until one can grow, rewrites
// the changed tail, then reads the run out through the registered read port
// at one element per cycle while out is not stalled. A restart or first
// request writes the whole run before reading it out; a done result goes
// straight out. Out stalls hold the readout. Reset clears the flags and the
// valid bits of the element store at once.
// ----------------------------------------------------------------------------
module k_of_n_combination_generator #(
	parameter int MAX_CHOOSE = kofn_pkg::MAX_CHOOSE_DEF,
	parameter int MAX_SET    = kofn_pkg::MAX_SET_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             restart,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [kofn_pkg::VALUE_W-1:0]     element_value,
	output logic [kofn_pkg::POSITION_W-1:0]  element_position,
	output logic                             last_of_run,
	output logic                             done_res,
	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kofn_pkg::PADDR_W-1:0]     paddr,
	input  logic [kofn_pkg::PDATA_W-1:0]     pwdata,
	output logic [kofn_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import kofn_pkg::*;

	localparam int EW = $clog2(MAX_SET + 1);
	localparam int KW = $clog2(MAX_CHOOSE + 1);
	localparam int PW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
	localparam int NW = (EW > SET_SIZE_W) ? EW : SET_SIZE_W;
	localparam int MW = (NW > KW) ? NW : KW;
	localparam int CW = ((MW > CHOOSE_W) ? MW : CHOOSE_W) + 1;

	kofn_state_t state_q, state_d;

	logic [SET_SIZE_W-1:0] set_size_q;
	logic [CHOOSE_W-1:0]   choose_count_q;

	logic          started_q, exhausted_q;
	logic [EW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] scan_q, rd_idx_s1, wpos_q, p_q;
	logic          issue_q, rdv_s1;
	logic [EW-1:0] wval_q;
	logic          out_valid_q;

	logic [CW-1:0] n_sat, k_sat;
	logic          accept, out_free, started_eff, exh_eff, go_done;
	logic          found, scan_none, wpos_last, p_last, load_elem, load_done;
	logic          rd_en, wr_en;
	logic [PW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	logic [CW-1:0] limit;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q     <= SET_SIZE_RST;
			choose_count_q <= CHOOSE_COUNT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SET_SIZE:     set_size_q     <= pwdata[SET_SIZE_W-1:0];
				REG_CHOOSE_COUNT: choose_count_q <= pwdata[CHOOSE_W-1:0];
				default:          ;
			endcase
		end
	end
	assign prdata = (paddr[2] == REG_CHOOSE_COUNT) ? PDATA_W'(choose_count_q)
	                                               : PDATA_W'(set_size_q);

	// Saturated n and k, and the request decision.
	assign n_sat = (CW'(set_size_q) > CW'(MAX_SET)) ? CW'(MAX_SET) : CW'(set_size_q);
	assign k_sat = (CW'(choose_count_q) > CW'(MAX_CHOOSE)) ? CW'(MAX_CHOOSE)
	                                                       : CW'(choose_count_q);
	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign started_eff = started_q && !restart;
	assign exh_eff     = exhausted_q && !restart;
	assign go_done     = exh_eff || (k_sat == '0) || (k_sat > n_sat);

	// Growth limit of the position whose element just came back: n-k+1+i.
	assign limit     = CW'(n_q) - CW'(k_q) + CW'(1) + CW'(rd_idx_s1);
	assign found     = rdv_s1 && (CW'(rd_data) < limit);
	assign scan_none = rdv_s1 && !found && (rd_idx_s1 == '0);

	assign out_free  = !out_valid_q || !out_stall;
	assign wpos_last = (KW'(wpos_q) == k_q - KW'(1));
	assign p_last    = (KW'(p_q) == k_q - KW'(1));

	// Next state and memory controls.
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = p_q;
		wr_en     = 1'b0;
		load_elem = 1'b0;
		load_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (go_done) begin
						state_d = ST_DONE_OUT;
					end else if (!started_eff) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en   = issue_q;
				rd_addr = scan_q;
				if (found) begin
					state_d = ST_WRITE;
				end else if (scan_none) begin
					state_d = ST_DONE_OUT;
				end
			end
			ST_WRITE: begin
				wr_en = 1'b1;
				if (wpos_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				rd_en   = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				rd_addr = p_q + PW'(1);
				if (out_free) begin
					load_elem = 1'b1;
					rd_en     = !p_last;
					if (p_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DONE_OUT: begin
				if (out_free) begin
					load_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control flags, scan issue and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			exhausted_q <= 1'b0;
			issue_q     <= 1'b0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_SCAN) && issue_q;
			if (accept) begin
				if (go_done) begin
					started_q   <= started_eff;
					exhausted_q <= 1'b1;
				end else begin
					started_q   <= 1'b1;
					exhausted_q <= 1'b0;
					issue_q     <= started_eff;
				end
			end
			if (state_q == ST_SCAN) begin
				if (found || scan_none || (scan_q == '0)) begin
					issue_q <= 1'b0;
				end
				if (scan_none) begin
					exhausted_q <= 1'b1;
				end
			end
			if (load_elem || load_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) begin
			n_q    <= EW'(n_sat);
			k_q    <= KW'(k_sat);
			scan_q <= PW'(k_sat - CW'(1));
			wpos_q <= '0;
			wval_q <= EW'(1);
		end
		if ((state_q == ST_SCAN) && issue_q) begin
			scan_q <= scan_q - PW'(1);
		end
		if (found && (state_q == ST_SCAN)) begin
			wpos_q <= rd_idx_s1;
			wval_q <= rd_data + EW'(1);
		end
		if (state_q == ST_WRITE) begin
			wpos_q <= wpos_q + PW'(1);
			wval_q <= wval_q + EW'(1);
			if (wpos_last) begin
				p_q <= '0;
			end
		end
		if (load_elem) begin
			element_value    <= VALUE_W'(rd_data);
			element_position <= POSITION_W'(p_q);
			last_of_run      <= p_last;
			done_res         <= 1'b0;
			p_q              <= p_q + PW'(1);
		end
		if (load_done) begin
			element_value    <= '0;
			element_position <= '0;
			last_of_run      <= 1'b1;
			done_res         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// Element store.
	kofn_comb_mem #(
		.DEPTH (MAX_CHOOSE),
		.DW    (EW),
		.AW    (PW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wpos_q),
		.wr_data (wval_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
